// ===== design/ffh_pkg.sv =====
// Shared widths, product table and result codes of the focal-from-homography block.
package ffh_pkg;

    localparam int ENT_W        = 64;   // entries are sign-extended to this width inside
    localparam int PROD_W       = 128;
    localparam int VAL_W        = 130;
    localparam int MAG_W        = 129;
    localparam int NUM_PRODS    = 14;
    localparam int FRONT_STAGES = 8;
    localparam int DIV_STEPS    = 64;
    localparam int ROOT_STEPS   = 32;
    localparam int FRAC_SHIFT   = 32;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [2:0]               ent_idx_t;
    typedef logic [1:0]               cls_t;
    typedef logic [1:0]               found_t;

    // Entry positions within an input item.
    localparam ent_idx_t E_H00 = 3'd0;
    localparam ent_idx_t E_H01 = 3'd1;
    localparam ent_idx_t E_H02 = 3'd2;
    localparam ent_idx_t E_H10 = 3'd3;
    localparam ent_idx_t E_H11 = 3'd4;
    localparam ent_idx_t E_H12 = 3'd5;
    localparam ent_idx_t E_H20 = 3'd6;
    localparam ent_idx_t E_H21 = 3'd7;

    // Product slots.
    localparam int P_S00  = 0;
    localparam int P_S01  = 1;
    localparam int P_S10  = 2;
    localparam int P_S11  = 3;
    localparam int P_0212 = 4;
    localparam int P_0010 = 5;
    localparam int P_0111 = 6;
    localparam int P_1212 = 7;
    localparam int P_0202 = 8;
    localparam int P_0001 = 9;
    localparam int P_1011 = 10;
    localparam int P_2021 = 11;
    localparam int P_2121 = 12;
    localparam int P_2020 = 13;

    localparam ent_idx_t PROD_A [NUM_PRODS] = '{
        E_H00, E_H01, E_H10, E_H11, E_H02, E_H00, E_H01,
        E_H12, E_H02, E_H00, E_H10, E_H20, E_H21, E_H20
    };
    localparam ent_idx_t PROD_B [NUM_PRODS] = '{
        E_H00, E_H01, E_H10, E_H11, E_H12, E_H10, E_H11,
        E_H12, E_H02, E_H01, E_H11, E_H21, E_H21, E_H20
    };

    // Candidate classes.
    localparam cls_t CL_NEG  = 2'd0;
    localparam cls_t CL_ZERO = 2'd1;
    localparam cls_t CL_POS  = 2'd2;

    // Found codes.
    localparam found_t FOUND_NONE = 2'd0;
    localparam found_t FOUND_F0   = 2'd1;
    localparam found_t FOUND_F1   = 2'd2;
    localparam found_t FOUND_BOTH = 2'd3;

endpackage

// ===== design/ffh_root.sv =====
// Pipelined integer square root: 64-bit radicand, 32-bit floor root, one bit per stage.
module ffh_root (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] din,
    output logic [31:0] dout
);

    logic [33:0] rem_reg  [ffh_pkg::ROOT_STEPS];
    logic [31:0] root_reg [ffh_pkg::ROOT_STEPS];
    logic [63:0] rest_reg [ffh_pkg::ROOT_STEPS];

    for (genvar k = 0; k < ffh_pkg::ROOT_STEPS; k++) begin : g_step
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] rest_in;
        logic [33:0] rem_shift;
        logic [33:0] trial;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rest_in = din;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rest_in = rest_reg[k-1];
        end

        // The partial remainder never exceeds twice the partial root, so 32 bits carry it.
        assign rem_shift = {rem_in[31:0], rest_in[63:62]};
        assign trial     = {root_in, 2'b01};

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_shift >= trial) begin
                    rem_reg[k]  <= rem_shift - trial;
                    root_reg[k] <= {root_in[30:0], 1'b1};
                end else begin
                    rem_reg[k]  <= rem_shift;
                    root_reg[k] <= {root_in[30:0], 1'b0};
                end
                rest_reg[k] <= {rest_in[61:0], 2'b00};
            end
        end
    end

    assign dout = root_reg[ffh_pkg::ROOT_STEPS-1];

endmodule

// ===== design/focal_from_homography.sv =====
// Top level: focal-length estimate from one planar homography, fully pipelined.
//
// Input channel s_*: one item carries eight homography entries (h22 is not used),
// each ENTRY_WIDTH bits signed fixed point; the common scale cancels in every ratio.
// Result channel m_*: m_tdata is the focal estimate in unsigned Q16.16, saturated,
// and m_tuser the found code (none, first only, second only, both combined).
// One item is accepted every cycle while s_tready is high. The pipeline depth is set by the
// two 64-step restoring dividers that run in parallel and by two 32-step square-root
// pipelines in series, one bit of each per stage, after eight stages of split
// 32-bit multiplies, sums and candidate selection.
// The output register is backed by a one-item skid register. When the receiver
// stalls and a second result arrives, the skid register fills, s_tready falls and
// the whole pipeline holds its contents until the output is taken; nothing is lost.
// Reset (aresetn low, synchronous) clears all valid bits; the block accepts items
// in the first cycle after reset.
module focal_from_homography #(
    parameter int ENTRY_WIDTH = 48
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // From bit 0 up: h00, h01, h02, h10, h11, h12, h20, h21, ENTRY_WIDTH bits each.
    input  logic [8*ENTRY_WIDTH-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // From bit 0 up: focal (32 bits).
    output logic [31:0]                m_tdata,
    // From bit 0 up: found (2 bits).
    output logic [1:0]                 m_tuser
);

    localparam int NUM_ENTRIES = 8;
    localparam int NP          = ffh_pkg::NUM_PRODS;
    localparam int DIVS        = ffh_pkg::DIV_STEPS;
    localparam int ROOTS       = ffh_pkg::ROOT_STEPS;
    localparam int OK_LEN      = DIVS + ROOTS;
    localparam int PIPE_DEPTH  = ffh_pkg::FRONT_STAGES + DIVS + ROOTS + 1 + ROOTS;
    localparam int VW          = ffh_pkg::VAL_W;
    localparam int MW          = ffh_pkg::MAG_W;
    localparam int FS          = ffh_pkg::FRAC_SHIFT;

    logic en;
    logic [PIPE_DEPTH-1:0] vld_reg;

    logic tail_valid_reg;
    logic [31:0] tail_focal_reg;
    ffh_pkg::found_t tail_found_reg;
    logic out_valid_reg, skid_valid_reg;
    logic [31:0] out_focal_reg, skid_focal_reg;
    ffh_pkg::found_t out_found_reg, skid_found_reg;

    assign en       = ~skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // Entries sign-extended to a common width.
    logic signed [ffh_pkg::ENT_W-1:0] ent [NUM_ENTRIES];
    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            ent[i] = ffh_pkg::ENT_W'(signed'(s_tdata[i*ENTRY_WIDTH +: ENTRY_WIDTH]));
        end
    end

    // Stages 1 to 3: each 64x64 product from four 32-bit partial products.
    logic signed [63:0] pp_hh_reg [NP];
    logic signed [64:0] pp_hl_reg [NP];
    logic signed [64:0] pp_lh_reg [NP];
    logic [63:0]        pp_ll_reg [NP];
    logic signed [63:0] hh2_reg   [NP];
    logic [63:0]        ll2_reg   [NP];
    logic signed [65:0] mid_reg   [NP];
    ffh_pkg::prod_t     prod_reg  [NP];

    for (genvar p = 0; p < NP; p++) begin : g_prod
        logic signed [31:0] a_hi, b_hi;
        logic [31:0]        a_lo, b_lo;

        assign a_hi = ent[ffh_pkg::PROD_A[p]][63:32];
        assign a_lo = ent[ffh_pkg::PROD_A[p]][31:0];
        assign b_hi = ent[ffh_pkg::PROD_B[p]][63:32];
        assign b_lo = ent[ffh_pkg::PROD_B[p]][31:0];

        always_ff @(posedge aclk) begin
            if (en) begin
                pp_hh_reg[p] <= a_hi * b_hi;
                pp_hl_reg[p] <= a_hi * $signed({1'b0, b_lo});
                pp_lh_reg[p] <= $signed({1'b0, a_lo}) * b_hi;
                pp_ll_reg[p] <= a_lo * b_lo;
                hh2_reg[p]   <= pp_hh_reg[p];
                ll2_reg[p]   <= pp_ll_reg[p];
                mid_reg[p]   <= 66'(pp_hl_reg[p]) + 66'(pp_lh_reg[p]);
                prod_reg[p]  <= signed'({hh2_reg[p], ll2_reg[p]})
                              + (ffh_pkg::prod_t'(mid_reg[p]) <<< 32);
            end
        end
    end

    function automatic ffh_pkg::val_t wext(ffh_pkg::prod_t x);
        return ffh_pkg::val_t'(x);
    endfunction

    // Stage 4: first level of sums.
    ffh_pkg::val_t s4_rows0_reg, s4_rows1_reg, s4_cols0_reg, s4_cols1_reg;
    ffh_pkg::val_t s4_n1f0_reg, s4_d1f0_reg, s4_n2f0_reg;
    ffh_pkg::val_t s4_dotf1_reg, s4_d1f1_reg, s4_d2f1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_rows0_reg <= wext(prod_reg[ffh_pkg::P_S00]) + wext(prod_reg[ffh_pkg::P_S01]);
            s4_rows1_reg <= wext(prod_reg[ffh_pkg::P_S10]) + wext(prod_reg[ffh_pkg::P_S11]);
            s4_cols0_reg <= wext(prod_reg[ffh_pkg::P_S00]) + wext(prod_reg[ffh_pkg::P_S10]);
            s4_cols1_reg <= wext(prod_reg[ffh_pkg::P_S01]) + wext(prod_reg[ffh_pkg::P_S11]);
            s4_n1f0_reg  <= -wext(prod_reg[ffh_pkg::P_0212]);
            s4_d1f0_reg  <= wext(prod_reg[ffh_pkg::P_0010]) + wext(prod_reg[ffh_pkg::P_0111]);
            s4_n2f0_reg  <= wext(prod_reg[ffh_pkg::P_1212]) - wext(prod_reg[ffh_pkg::P_0202]);
            s4_dotf1_reg <= wext(prod_reg[ffh_pkg::P_0001]) + wext(prod_reg[ffh_pkg::P_1011]);
            s4_d1f1_reg  <= wext(prod_reg[ffh_pkg::P_2021]);
            s4_d2f1_reg  <= wext(prod_reg[ffh_pkg::P_2121]) - wext(prod_reg[ffh_pkg::P_2020]);
        end
    end

    // Stage 5: candidates per estimate as numerator 1, denominator 1, numerator 2, denominator 2.
    ffh_pkg::val_t val_reg [2][4];

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg[0][0] <= s4_n1f0_reg;
            val_reg[0][1] <= s4_d1f0_reg;
            val_reg[0][2] <= s4_n2f0_reg;
            val_reg[0][3] <= s4_rows0_reg - s4_rows1_reg;
            val_reg[1][0] <= -s4_dotf1_reg;
            val_reg[1][1] <= s4_d1f1_reg;
            val_reg[1][2] <= s4_cols0_reg - s4_cols1_reg;
            val_reg[1][3] <= s4_d2f1_reg;
        end
    end

    // Stages 6 to 8 and the dividers, one set per estimate.
    ffh_pkg::mag_t abs_reg  [2][4];
    logic          zero_reg [2][4];
    logic          neg_reg  [2][4];
    ffh_pkg::mag_t num_reg  [2];
    ffh_pkg::mag_t den_reg  [2];
    logic          ok7_reg  [2];
    logic [VW-1:0] r0_reg   [2];
    ffh_pkg::mag_t den8_reg [2];
    logic [31:0]   low8_reg [2];
    logic          sat8_reg [2];
    logic          ok8_reg  [2];

    logic [VW-1:0] div_rem_reg [2][DIVS];
    ffh_pkg::mag_t div_den_reg [2][DIVS];
    logic [31:0]   div_low_reg [2][DIVS];
    logic [63:0]   div_quo_reg [2][DIVS];
    logic          div_sat_reg [2][DIVS];
    logic [OK_LEN-1:0] ok_dly_reg [2];
    logic [63:0]   q_fin  [2];
    logic [31:0]   f_root [2];

    for (genvar e = 0; e < 2; e++) begin : g_est
        ffh_pkg::cls_t cls1, cls2;
        logic          use2, ok;

        for (genvar k = 0; k < 4; k++) begin : g_abs
            always_ff @(posedge aclk) begin
                if (en) begin
                    abs_reg[e][k]  <= ffh_pkg::mag_t'(val_reg[e][k][VW-1] ? -val_reg[e][k]
                                                                         : val_reg[e][k]);
                    zero_reg[e][k] <= (val_reg[e][k] == '0);
                    neg_reg[e][k]  <= val_reg[e][k][VW-1];
                end
            end
        end

        // A zero denominator makes a candidate invalid, a zero numerator makes it zero.
        always_comb begin
            if (zero_reg[e][1]) begin
                cls1 = ffh_pkg::CL_NEG;
            end else if (zero_reg[e][0]) begin
                cls1 = ffh_pkg::CL_ZERO;
            end else begin
                cls1 = (neg_reg[e][0] != neg_reg[e][1]) ? ffh_pkg::CL_NEG : ffh_pkg::CL_POS;
            end
            if (zero_reg[e][3]) begin
                cls2 = ffh_pkg::CL_NEG;
            end else if (zero_reg[e][2]) begin
                cls2 = ffh_pkg::CL_ZERO;
            end else begin
                cls2 = (neg_reg[e][2] != neg_reg[e][3]) ? ffh_pkg::CL_NEG : ffh_pkg::CL_POS;
            end
            use2 = 1'b0;
            ok   = 1'b0;
            if (cls1 == ffh_pkg::CL_POS && cls2 == ffh_pkg::CL_POS) begin
                ok   = 1'b1;
                use2 = !(abs_reg[e][1] > abs_reg[e][3]);
            end else if (cls1 == ffh_pkg::CL_POS && cls2 == ffh_pkg::CL_NEG) begin
                ok = 1'b1;
            end else if (cls1 == ffh_pkg::CL_NEG && cls2 == ffh_pkg::CL_POS) begin
                ok   = 1'b1;
                use2 = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[e] <= use2 ? abs_reg[e][2] : abs_reg[e][0];
                den_reg[e] <= use2 ? abs_reg[e][3] : abs_reg[e][1];
                ok7_reg[e] <= ok;
                // The quotient overflows 64 bits exactly when num / 2^32 reaches den.
                sat8_reg[e] <= ({{FS{1'b0}}, num_reg[e][MW-1:FS]} >= den_reg[e]);
                r0_reg[e]   <= (({{FS{1'b0}}, num_reg[e][MW-1:FS]} >= den_reg[e])) ? '0
                               : VW'({num_reg[e][MW-1:FS]});
                den8_reg[e] <= den_reg[e];
                low8_reg[e] <= num_reg[e][FS-1:0];
                ok8_reg[e]  <= ok7_reg[e];
                ok_dly_reg[e] <= {ok_dly_reg[e][OK_LEN-2:0], ok8_reg[e]};
            end
        end

        // Restoring division of num * 2^32 by den, one quotient bit per stage.
        for (genvar j = 0; j < DIVS; j++) begin : g_div
            logic [VW-1:0] rem_in, rem_shift;
            ffh_pkg::mag_t den_in;
            logic [31:0]   low_in;
            logic [63:0]   quo_in;
            logic          sat_in;

            if (j == 0) begin : g_first
                assign rem_in = r0_reg[e];
                assign den_in = den8_reg[e];
                assign low_in = low8_reg[e];
                assign quo_in = '0;
                assign sat_in = sat8_reg[e];
            end else begin : g_next
                assign rem_in = div_rem_reg[e][j-1];
                assign den_in = div_den_reg[e][j-1];
                assign low_in = div_low_reg[e][j-1];
                assign quo_in = div_quo_reg[e][j-1];
                assign sat_in = div_sat_reg[e][j-1];
            end

            assign rem_shift = {rem_in[VW-2:0], low_in[31]};

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (rem_shift >= {1'b0, den_in}) begin
                        div_rem_reg[e][j] <= rem_shift - {1'b0, den_in};
                        div_quo_reg[e][j] <= {quo_in[62:0], 1'b1};
                    end else begin
                        div_rem_reg[e][j] <= rem_shift;
                        div_quo_reg[e][j] <= {quo_in[62:0], 1'b0};
                    end
                    div_den_reg[e][j] <= den_in;
                    div_low_reg[e][j] <= {low_in[30:0], 1'b0};
                    div_sat_reg[e][j] <= sat_in;
                end
            end
        end

        assign q_fin[e] = div_sat_reg[e][DIVS-1] ? '1 : div_quo_reg[e][DIVS-1];

        ffh_root u_root (
            .aclk (aclk),
            .en   (en),
            .din  (q_fin[e]),
            .dout (f_root[e])
        );
    end

    // Combination stage: product of the two estimates, then its square root.
    logic [31:0] mul_f_reg  [2];
    logic        mul_ok_reg [2];
    logic [63:0] mul_prod_reg;
    logic [31:0] f_both;
    logic [31:0] f_dly_reg  [2][ROOTS];
    logic [ROOTS-1:0] ok2_dly_reg [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_prod_reg <= f_root[0] * f_root[1];
            for (int e = 0; e < 2; e++) begin
                mul_f_reg[e]   <= f_root[e];
                mul_ok_reg[e]  <= ok_dly_reg[e][OK_LEN-1];
                ok2_dly_reg[e] <= {ok2_dly_reg[e][ROOTS-2:0], mul_ok_reg[e]};
                f_dly_reg[e][0] <= mul_f_reg[e];
                for (int k = 1; k < ROOTS; k++) begin
                    f_dly_reg[e][k] <= f_dly_reg[e][k-1];
                end
            end
        end
    end

    ffh_root u_root_both (
        .aclk (aclk),
        .en   (en),
        .din  (mul_prod_reg),
        .dout (f_both)
    );

    // Final stage: pick the result and its found code.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_valid_reg <= 1'b0;
        end else if (en) begin
            tail_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (ok2_dly_reg[0][ROOTS-1] && ok2_dly_reg[1][ROOTS-1]) begin
                tail_focal_reg <= f_both;
                tail_found_reg <= ffh_pkg::FOUND_BOTH;
            end else if (ok2_dly_reg[0][ROOTS-1]) begin
                tail_focal_reg <= f_dly_reg[0][ROOTS-1];
                tail_found_reg <= ffh_pkg::FOUND_F0;
            end else if (ok2_dly_reg[1][ROOTS-1]) begin
                tail_focal_reg <= f_dly_reg[1][ROOTS-1];
                tail_found_reg <= ffh_pkg::FOUND_F1;
            end else begin
                tail_focal_reg <= '0;
                tail_found_reg <= ffh_pkg::FOUND_NONE;
            end
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!skid_valid_reg) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= tail_valid_reg;
            end else if (tail_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg) begin
            if (!out_valid_reg || m_tready) begin
                out_focal_reg <= tail_focal_reg;
                out_found_reg <= tail_found_reg;
            end else begin
                skid_focal_reg <= tail_focal_reg;
                skid_found_reg <= tail_found_reg;
            end
        end else if (m_tready) begin
            out_focal_reg <= skid_focal_reg;
            out_found_reg <= skid_found_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_focal_reg;
    assign m_tuser  = out_found_reg;

endmodule

// ===== design/ffh_check.sv =====
// Port-level assertions for the focal-from-homography block, bound to its top level.
module ffh_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Nothing is offered in the cycle after a reset.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // A stalled result keeps its value until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // With no estimate found the focal value is zero.
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ffh_pkg::FOUND_NONE |-> m_tdata == '0)
        else $error("focal not zero when nothing found");

    // Input back-pressure only follows a stalled output.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

endmodule

bind focal_from_homography ffh_check u_ffh_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
